[design/stl_pkg.sv]
// stl_pkg: shared types, constants and character class helpers for the token lexer
// used by stl_front, stl_queue, stl_back and source_token_lexer_core
package stl_pkg;

    localparam int OFFSET_WIDTH  = 16;
    localparam int NUMBER_WIDTH  = 32;
    localparam int LEN_W         = 8;
    localparam int LENGTH_MAX    = 255;
    localparam int KIND_W        = 5;
    localparam int CHAR_W        = 8;
    localparam int PREFIX_W      = 48;
    localparam int PREFIX_BYTES  = PREFIX_W / CHAR_W;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DATA_BITS = NUMBER_WIDTH + OFFSET_WIDTH + LEN_W;
    localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;
    localparam logic [NUMBER_WIDTH-1:0] NUM_MAX = '1;
    localparam logic [LEN_W-1:0]        LEN_SAT = LEN_W'(LENGTH_MAX);

    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;

    // keyword spellings, first byte highest
    localparam logic [PREFIX_W-1:0] W_IF     = 48'h0000_0000_6966;
    localparam logic [PREFIX_W-1:0] W_INT    = 48'h0000_0069_6E74;
    localparam logic [PREFIX_W-1:0] W_ELSE   = 48'h0000_656C_7365;
    localparam logic [PREFIX_W-1:0] W_WHILE  = 48'h0077_6869_6C65;
    localparam logic [PREFIX_W-1:0] W_DOUBLE = 48'h646F_7562_6C65;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NUM  = 2'd1,
        MODE_WORD = 2'd2,
        MODE_EQ   = 2'd3
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        K_INT    = 5'd0,
        K_PLUS   = 5'd1,
        K_MINUS  = 5'd2,
        K_MUL    = 5'd3,
        K_DIV    = 5'd4,
        K_EQUAL  = 5'd5,
        K_ASSIGN = 5'd6,
        K_LPAREN = 5'd7,
        K_RPAREN = 5'd8,
        K_LBRACE = 5'd9,
        K_RBRACE = 5'd10,
        K_SEMI   = 5'd11,
        K_IF     = 5'd12,
        K_ELSE   = 5'd13,
        K_WHILE  = 5'd14,
        K_TYPE   = 5'd15,
        K_IDENT  = 5'd16,
        K_END    = 5'd17,
        K_ERROR  = 5'd18
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [NUMBER_WIDTH-1:0] value;
        logic [OFFSET_WIDTH-1:0] start;
        logic [LEN_W-1:0]        len;
    } t_token;

    // results of one source item, tok0 goes out first
    typedef struct packed {
        t_token tok0;
        t_token tok1;
        logic   two;
    } t_entry;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic t_kind op_kind(input logic [CHAR_W-1:0] c);
        t_kind k;
        case (c)
            CH_PLUS:   k = K_PLUS;
            CH_MINUS:  k = K_MINUS;
            CH_STAR:   k = K_MUL;
            CH_SLASH:  k = K_DIV;
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_SEMI:   k = K_SEMI;
            default:   k = K_ERROR;
        endcase
        return k;
    endfunction

endpackage

[design/stl_front.sv]
// stl_front: lexer FSM, takes one source byte per cycle while i_room, forms tokens
// depends on stl_pkg; writes at most one result entry per item into stl_queue
module stl_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [stl_pkg::CHAR_W-1:0]      i_char,
    input  logic                            i_last,
    input  logic                            i_room,
    output logic                            o_ready,
    output logic                            o_push,
    output stl_pkg::t_entry                 o_entry
);
    import stl_pkg::*;

    t_mode                   r_mode, n_mode;
    logic [OFFSET_WIDTH-1:0] r_pos, n_pos;
    logic [OFFSET_WIDTH-1:0] r_start, n_start;
    logic [LEN_W-1:0]        r_len, n_len;
    logic [NUMBER_WIDTH-1:0] r_acc, n_acc;
    logic [PREFIX_W-1:0]     r_prefix, n_prefix;

    logic                    accept;
    logic                    have0, have1, consumed;
    t_token                  tok0, tok1, fl_tok;
    t_kind                   w_kind;
    logic [LEN_W-1:0]        len_inc;
    logic [NUMBER_WIDTH+3:0] acc_wide;
    logic [NUMBER_WIDTH-1:0] digit;

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;

    always_comb begin
        if (r_len == LEN_W'(2) && r_prefix == W_IF) begin
            w_kind = K_IF;
        end else if (r_len == LEN_W'(4) && r_prefix == W_ELSE) begin
            w_kind = K_ELSE;
        end else if (r_len == LEN_W'(5) && r_prefix == W_WHILE) begin
            w_kind = K_WHILE;
        end else if (r_len == LEN_W'(3) && r_prefix == W_INT) begin
            w_kind = K_TYPE;
        end else if (r_len == LEN_W'(6) && r_prefix == W_DOUBLE) begin
            w_kind = K_TYPE;
        end else begin
            w_kind = K_IDENT;
        end
    end

    always_comb begin
        fl_tok.value = '0;
        fl_tok.start = r_start;
        fl_tok.len   = r_len;
        case (r_mode)
            MODE_NUM: begin
                fl_tok.kind  = K_INT;
                fl_tok.value = r_acc;
            end
            MODE_WORD: fl_tok.kind = w_kind;
            MODE_EQ: begin
                fl_tok.kind = K_ASSIGN;
                fl_tok.len  = LEN_W'(1);
            end
            default: fl_tok.kind = K_ERROR;
        endcase
    end

    // saturating acc * 10 + digit
    assign digit    = NUMBER_WIDTH'(i_char - CH_ZERO);
    assign acc_wide = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {4'b0, digit};
    assign len_inc  = (r_len < LEN_SAT) ? r_len + LEN_W'(1) : r_len;

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_start  = r_start;
        n_len    = r_len;
        n_acc    = r_acc;
        n_prefix = r_prefix;
        have0    = 1'b0;
        have1    = 1'b0;
        consumed = 1'b0;
        tok0     = fl_tok;
        tok1     = '{kind: op_kind(i_char), value: '0, start: r_pos, len: LEN_W'(1)};
        if (i_last) begin
            have0    = (r_mode != MODE_IDLE);
            have1    = 1'b1;
            tok1     = '{kind: K_END, value: '0, start: r_pos, len: '0};
            n_mode   = MODE_IDLE;
            n_pos    = '0;
            n_start  = '0;
            n_len    = '0;
            n_acc    = '0;
            n_prefix = '0;
        end else begin
            case (r_mode)
                MODE_EQ: begin
                    have0  = 1'b1;
                    n_mode = MODE_IDLE;
                    if (i_char == CH_EQ) begin
                        tok0.kind = K_EQUAL;
                        tok0.len  = LEN_W'(2);
                        consumed  = 1'b1;
                    end
                end
                MODE_NUM: begin
                    if (is_digit(i_char)) begin
                        n_acc    = (acc_wide[NUMBER_WIDTH+3:NUMBER_WIDTH] != 4'b0) ?
                                   NUM_MAX : acc_wide[NUMBER_WIDTH-1:0];
                        n_len    = len_inc;
                        consumed = 1'b1;
                    end else begin
                        have0  = 1'b1;
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_WORD: begin
                    if (is_digit(i_char) || is_letter(i_char)) begin
                        if (r_len < LEN_W'(PREFIX_BYTES)) begin
                            n_prefix = {r_prefix[PREFIX_W-CHAR_W-1:0], i_char};
                        end
                        n_len    = len_inc;
                        consumed = 1'b1;
                    end else begin
                        have0  = 1'b1;
                        n_mode = MODE_IDLE;
                    end
                end
                default: begin
                end
            endcase
            if (!consumed && !is_space(i_char)) begin
                if (is_digit(i_char)) begin
                    n_mode  = MODE_NUM;
                    n_start = r_pos;
                    n_len   = LEN_W'(1);
                    n_acc   = digit;
                end else if (is_letter(i_char)) begin
                    n_mode   = MODE_WORD;
                    n_start  = r_pos;
                    n_len    = LEN_W'(1);
                    n_prefix = PREFIX_W'(i_char);
                end else if (i_char == CH_EQ) begin
                    n_mode  = MODE_EQ;
                    n_start = r_pos;
                    n_len   = LEN_W'(1);
                end else begin
                    have1 = 1'b1;
                end
            end
            if (r_pos != OFF_MAX) begin
                n_pos = r_pos + OFFSET_WIDTH'(1);
            end
        end
    end

    always_comb begin
        if (have0) begin
            o_entry.tok0 = tok0;
            o_entry.tok1 = tok1;
            o_entry.two  = have1;
        end else begin
            o_entry.tok0 = tok1;
            o_entry.tok1 = tok1;
            o_entry.two  = 1'b0;
        end
    end

    assign o_push = accept && (have0 || have1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_acc    <= '0;
            r_prefix <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_len    <= n_len;
            r_acc    <= n_acc;
            r_prefix <= n_prefix;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last |=> r_mode == MODE_IDLE && r_pos == '0)
        else $error("state not cleared after end of source");

    a_pos_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_last && r_pos != OFF_MAX |=> r_pos == $past(r_pos) + OFFSET_WIDTH'(1))
        else $error("byte position did not advance");

    a_end_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last |-> o_push && o_entry.tok0.kind != K_END || !o_entry.two)
        else $error("end token not placed last");

endmodule

[design/stl_queue.sv]
// stl_queue: short result queue between the lexer front and the output stage
// depends on stl_pkg; one entry holds all tokens of one source item
module stl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  stl_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_room,
    output logic            o_valid,
    output stl_pkg::t_entry o_head
);
    import stl_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_count;

    assign o_room  = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room)
        else $error("push into full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

[design/stl_back.sv]
// stl_back: output stage, sends the tokens of each queued entry one per cycle while i_ready
// depends on stl_pkg; reads the head of stl_queue
module stl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  stl_pkg::t_entry i_head,
    output logic            o_pop,
    input  logic            i_ready,
    output logic            o_valid,
    output stl_pkg::t_token o_tok,
    output logic            o_last
);
    import stl_pkg::*;

    logic   r_valid, r_sel, r_last;
    t_token r_tok;
    logic   load;

    assign load  = i_head_valid && (!r_valid || i_ready);
    assign o_pop = load && (r_sel || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= !r_sel && i_head.two;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= r_sel ? i_head.tok1 : i_head.tok0;
            r_last <= r_sel || !i_head.two;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_last  = r_last;

    a_second_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> i_head_valid && i_head.two)
        else $error("second token selected without a two-token entry");

endmodule

[design/source_token_lexer_core.sv]
// source_token_lexer_core: top level of the streaming source lexer
// depends on stl_pkg, stl_front, stl_queue and stl_back
//
// The lexer takes one source byte per clock cycle while the queue has room
// and never waits on the byte itself: a front stage keeps the scanning state
// (mode, position, run start, run length, number value, first six word
// bytes) and writes all tokens caused by a byte into a four-entry queue; an
// output register sends them on, one token per cycle while the receiver is
// ready. A byte may cause two tokens, so the sustained rate is one byte per
// cycle as long as the receiver is ready and the average is at most one token
// per byte. Tokens pass the queue and then the output register. The input
// stalls only when the queue is full. tlast on the input marks end of source:
// pending token, then an end token, then offsets restart at zero.
module source_token_lexer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [stl_pkg::CHAR_W-1:0]         i_s_axis_tdata,   // char_byte
    input  logic                               i_s_axis_tlast,   // end_of_input
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [stl_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,   // number_value, start_offset, token_length
    output logic [stl_pkg::KIND_W-1:0]         o_m_axis_tuser,   // token_kind
    output logic                               o_m_axis_tlast    // last_of_run
);
    import stl_pkg::*;

    logic   push, pop, room, head_valid;
    t_entry entry, head;
    t_token tok;

    stl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_char  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_room  (room),
        .o_ready (o_s_axis_tready),
        .o_push  (push),
        .o_entry (entry)
    );

    stl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_room  (room),
        .o_valid (head_valid),
        .o_head  (head)
    );

    stl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_ready      (i_m_axis_tready),
        .o_valid      (o_m_axis_tvalid),
        .o_tok        (tok),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'({tok.len, tok.start, tok.value});
    assign o_m_axis_tuser = tok.kind;

endmodule

[verif/testbench.sv]
// testbench for source_token_lexer_core: byte stream in, token stream out
// self-checking against an in-bench scanner model; depends on stl_pkg and the rtl
`timescale 1ns / 100ps

module testbench;
    import stl_pkg::*;

    localparam int DIR_N          = 26;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_AFTER     = 200;
    localparam int HOLD_CYCLES    = 400;

    localparam logic [7:0]  RUN_CAP   = 8'd255;
    localparam logic [15:0] POS_CAP   = 16'hFFFF;
    localparam logic [31:0] VALUE_CAP = 32'hFFFF_FFFF;

    localparam logic [47:0] SPELL_IF     = 48'h6966;
    localparam logic [47:0] SPELL_INT    = 48'h69_6E74;
    localparam logic [47:0] SPELL_ELSE   = 48'h656C_7365;
    localparam logic [47:0] SPELL_WHILE  = 48'h77_6869_6C65;
    localparam logic [47:0] SPELL_DOUBLE = 48'h646F_7562_6C65;

    typedef struct packed {
        logic [7:0]              ch;
        logic                    eoi;
        logic                    typed;
        t_kind                   kind;
        logic [NUMBER_WIDTH-1:0] value;
        logic [OFFSET_WIDTH-1:0] start;
        logic [LEN_W-1:0]        len;
    } t_src_row;

    typedef struct packed {
        t_token tok;
        logic   last;
    } t_tok_exp;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [CHAR_W-1:0]      i_s_axis_tdata = '0;   // char_byte
    logic                   i_s_axis_tlast = 1'b0; // end_of_input
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;        // number_value, start_offset, token_length
    logic [KIND_W-1:0]      o_m_axis_tuser;        // token_kind
    logic                   o_m_axis_tlast;        // last_of_run

    source_token_lexer_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // directed rows, typed expectations where obvious
    t_src_row dir_rows [DIR_N] = '{
        '{"+",   1'b0, 1'b1, K_PLUS,   32'd0, 16'd0,  8'd1},
        '{"_",   1'b0, 1'b1, K_ERROR,  32'd0, 16'd1,  8'd1},
        '{8'h00, 1'b0, 1'b1, K_ERROR,  32'd0, 16'd2,  8'd1},
        '{8'hFF, 1'b0, 1'b1, K_ERROR,  32'd0, 16'd3,  8'd1},
        '{" ",   1'b0, 1'b0, K_INT,    32'd0, 16'd0,  8'd0},
        '{"=",   1'b0, 1'b0, K_INT,    32'd0, 16'd0,  8'd0},
        '{"=",   1'b0, 1'b1, K_EQUAL,  32'd0, 16'd5,  8'd2},
        '{"=",   1'b0, 1'b0, K_INT,    32'd0, 16'd0,  8'd0},
        '{"x",   1'b0, 1'b1, K_ASSIGN, 32'd0, 16'd7,  8'd1},
        '{"9",   1'b0, 1'b0, K_INT,    32'd0, 16'd0,  8'd0},
        '{8'h09, 1'b0, 1'b0, K_INT,    32'd0, 16'd0,  8'd0},
        '{"4",   1'b0, 1'b0, K_INT,    32'd0, 16'd0,  8'd0},
        '{"q",   1'b0, 1'b0, K_INT,    32'd0, 16'd0,  8'd0},
        '{"(",   1'b0, 1'b0, K_INT,    32'd0, 16'd0,  8'd0},
        '{")",   1'b0, 1'b1, K_RPAREN, 32'd0, 16'd14, 8'd1},
        '{"{",   1'b0, 1'b1, K_LBRACE, 32'd0, 16'd15, 8'd1},
        '{"}",   1'b0, 1'b1, K_RBRACE, 32'd0, 16'd16, 8'd1},
        '{"-",   1'b0, 1'b1, K_MINUS,  32'd0, 16'd17, 8'd1},
        '{"*",   1'b0, 1'b1, K_MUL,    32'd0, 16'd18, 8'd1},
        '{"/",   1'b0, 1'b1, K_DIV,    32'd0, 16'd19, 8'd1},
        '{";",   1'b0, 1'b1, K_SEMI,   32'd0, 16'd20, 8'd1},
        '{"i",   1'b0, 1'b0, K_INT,    32'd0, 16'd0,  8'd0},
        '{"f",   1'b0, 1'b0, K_INT,    32'd0, 16'd0,  8'd0},
        '{"=",   1'b0, 1'b0, K_INT,    32'd0, 16'd0,  8'd0},
        '{8'hA5, 1'b1, 1'b0, K_INT,    32'd0, 16'd0,  8'd0},
        '{8'h3D, 1'b1, 1'b1, K_END,    32'd0, 16'd0,  8'd0}
    };

    string kw_list [5] = '{"if", "else", "while", "int", "double"};
    string num_edges [5] = '{"4294967295", "4294967296", "4294967290", "99999999999", "0"};
    logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    t_src_row src_q [$];
    t_tok_exp pending_tokens [$];
    int fails = 0;

    // scanner state
    t_mode                   lx_mode  = MODE_IDLE;
    logic [OFFSET_WIDTH-1:0] lx_pos   = '0;
    logic [OFFSET_WIDTH-1:0] lx_start = '0;
    logic [LEN_W-1:0]        lx_len   = '0;
    logic [NUMBER_WIDTH-1:0] lx_num   = '0;
    logic [47:0]             lx_word  = '0;
    t_token                  scan_out [2];
    int                      scan_n;

    function automatic logic ch_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic ch_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic ch_blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void scan_emit(input t_kind k, input logic [NUMBER_WIDTH-1:0] v,
                                      input logic [OFFSET_WIDTH-1:0] s, input logic [LEN_W-1:0] l);
        scan_out[scan_n] = '{kind: k, value: v, start: s, len: l};
        scan_n++;
    endfunction

    function automatic t_kind word_class();
        if (lx_len == 8'd2 && lx_word == SPELL_IF) return K_IF;
        if (lx_len == 8'd4 && lx_word == SPELL_ELSE) return K_ELSE;
        if (lx_len == 8'd5 && lx_word == SPELL_WHILE) return K_WHILE;
        if (lx_len == 8'd3 && lx_word == SPELL_INT) return K_TYPE;
        if (lx_len == 8'd6 && lx_word == SPELL_DOUBLE) return K_TYPE;
        return K_IDENT;
    endfunction

    function automatic void close_run();
        case (lx_mode)
            MODE_NUM:  scan_emit(K_INT, lx_num, lx_start, lx_len);
            MODE_WORD: scan_emit(word_class(), '0, lx_start, lx_len);
            MODE_EQ:   scan_emit(K_ASSIGN, '0, lx_start, 8'd1);
            default: ;
        endcase
        lx_mode = MODE_IDLE;
    endfunction

    function automatic void scan_byte(input logic [7:0] c, input logic eoi);
        logic                    fresh;
        logic [OFFSET_WIDTH-1:0] here;
        logic [63:0]             digit;
        t_kind                   k;
        scan_n = 0;
        fresh = 1'b1;
        here = lx_pos;
        if (eoi) begin
            close_run();
            scan_emit(K_END, '0, here, 8'd0);
            lx_pos = '0;
            lx_start = '0;
            lx_len = '0;
            lx_num = '0;
            lx_word = '0;
            return;
        end
        case (lx_mode)
            MODE_EQ: begin
                if (c == "=") begin
                    scan_emit(K_EQUAL, '0, lx_start, 8'd2);
                    lx_mode = MODE_IDLE;
                    fresh = 1'b0;
                end else begin
                    close_run();
                end
            end
            MODE_NUM: begin
                if (ch_digit(c)) begin
                    digit = 64'(c - "0");
                    if (64'(lx_num) > (64'(VALUE_CAP) - digit) / 10)
                        lx_num = VALUE_CAP;
                    else
                        lx_num = NUMBER_WIDTH'(64'(lx_num) * 10 + digit);
                    if (lx_len != RUN_CAP) lx_len++;
                    fresh = 1'b0;
                end else begin
                    close_run();
                end
            end
            MODE_WORD: begin
                if (ch_digit(c) || ch_letter(c)) begin
                    if (lx_len < 8'd6) lx_word = {lx_word[39:0], c};
                    if (lx_len != RUN_CAP) lx_len++;
                    fresh = 1'b0;
                end else begin
                    close_run();
                end
            end
            default: ;
        endcase
        if (fresh && !ch_blank(c)) begin
            if (ch_digit(c)) begin
                lx_mode = MODE_NUM;
                lx_start = here;
                lx_len = 8'd1;
                lx_num = NUMBER_WIDTH'(c - "0");
            end else if (ch_letter(c)) begin
                lx_mode = MODE_WORD;
                lx_start = here;
                lx_len = 8'd1;
                lx_word = {40'd0, c};
            end else if (c == "=") begin
                lx_mode = MODE_EQ;
                lx_start = here;
                lx_len = 8'd1;
            end else begin
                case (c)
                    "+":     k = K_PLUS;
                    "-":     k = K_MINUS;
                    "*":     k = K_MUL;
                    "/":     k = K_DIV;
                    "(":     k = K_LPAREN;
                    ")":     k = K_RPAREN;
                    "{":     k = K_LBRACE;
                    "}":     k = K_RBRACE;
                    ";":     k = K_SEMI;
                    default: k = K_ERROR;
                endcase
                scan_emit(k, '0, here, 8'd1);
            end
        end
        if (lx_pos != POS_CAP) lx_pos++;
    endfunction

    function automatic void accept_row(input t_src_row row);
        scan_byte(row.ch, row.eoi);
        if (row.typed) begin
            pending_tokens.push_back('{tok: '{kind: row.kind, value: row.value,
                                              start: row.start, len: row.len}, last: 1'b1});
        end else begin
            for (int i = 0; i < scan_n; i++)
                pending_tokens.push_back('{tok: scan_out[i], last: (i == scan_n - 1)});
        end
    endfunction

    // mostly short gaps, a few long ones, and quiet stretches with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 199) == 0) calm = $urandom_range(30, 120);
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void push_byte(input logic [7:0] c, input logic eoi);
        src_q.push_back('{ch: c, eoi: eoi, typed: 1'b0, kind: K_INT, value: '0,
                          start: '0, len: '0});
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 26) return 8'("A" + r);
        if (r < 52) return 8'("a" + r - 26);
        return 8'("0" + r - 52);
    endfunction

    function automatic void gen_token();
        string s;
        int    r;
        int    n;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            s = kw_list[$urandom_range(0, 4)];
            n = $urandom_range(0, 9);
            if (n < 2) s = {s, string'(rand_alnum())};
            else if (n == 2) s = s.substr(0, s.len() - 2);
            else if (n == 3) s[0] = s[0] ^ 8'h20;
            push_text(s);
        end else if (r < 30) begin
            n = ($urandom_range(0, 49) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 8);
            push_byte(8'("a" + $urandom_range(0, 25)), 1'b0);
            for (int i = 1; i < n; i++) push_byte(rand_alnum(), 1'b0);
        end else if (r < 45) begin
            if ($urandom_range(0, 9) == 0) begin
                push_text(num_edges[$urandom_range(0, 4)]);
            end else begin
                n = ($urandom_range(0, 49) == 0) ? $urandom_range(256, 300)
                                                 : $urandom_range(1, 12);
                for (int i = 0; i < n; i++) push_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
            end
        end else if (r < 75) begin
            s = "+-*/(){};";
            push_byte(s[$urandom_range(0, 8)], 1'b0);
        end else if (r < 85) begin
            push_byte("=", 1'b0);
            if ($urandom_range(0, 1)) push_byte("=", 1'b0);
        end else if (r < 97) begin
            push_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            // broken source: end mark in the middle of things
            push_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endfunction

    function automatic void gen_source();
        int ntok;
        int r;
        ntok = $urandom_range(1, 30);
        for (int t = 0; t < ntok; t++) begin
            r = $urandom_range(0, 9);
            if (r >= 5 && r < 9) begin
                push_byte(blanks[$urandom_range(0, 5)], 1'b0);
            end else if (r == 9) begin
                repeat ($urandom_range(2, 5)) push_byte(blanks[$urandom_range(0, 5)], 1'b0);
            end
            gen_token();
        end
        push_byte(8'($urandom_range(0, 255)), 1'b1);
    endfunction

    // sender
    int tx_gap = 0;
    int tx_calm = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                accept_row(src_q.pop_front());
                tx_gap = pick_gap(tx_calm);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (src_q.size() > 0) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= src_q[0].ch;
                    i_s_axis_tlast  <= src_q[0].eoi;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off so the input side backs up
    int rx_stall = 0;
    int rx_calm = 0;
    int rx_hold = 0;
    int rx_seen = 0;
    logic held_once = 1'b0;

    always @(posedge i_clk) begin
        if (o_m_axis_tvalid && i_m_axis_tready) rx_seen++;
        if (!held_once && rx_seen >= HOLD_AFTER) begin
            held_once = 1'b1;
            rx_hold = HOLD_CYCLES;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_stall = pick_gap(rx_calm);
        end
    end

    // token check
    always @(posedge i_clk) begin : token_check
        t_tok_exp                want;
        logic [NUMBER_WIDTH-1:0] got_value;
        logic [OFFSET_WIDTH-1:0] got_start;
        logic [LEN_W-1:0]        got_len;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_value = o_m_axis_tdata[NUMBER_WIDTH-1:0];
            got_start = o_m_axis_tdata[NUMBER_WIDTH +: OFFSET_WIDTH];
            got_len   = o_m_axis_tdata[NUMBER_WIDTH + OFFSET_WIDTH +: LEN_W];
            if (pending_tokens.size() == 0) begin
                $error("token with none expected: token_kind %0d", o_m_axis_tuser);
                fails++;
            end else begin
                want = pending_tokens.pop_front();
                if (o_m_axis_tuser != want.tok.kind) begin
                    $error("token_kind: expected %0d, actual %0d", want.tok.kind, o_m_axis_tuser);
                    fails++;
                end
                if (got_value != want.tok.value) begin
                    $error("number_value: expected %0d, actual %0d", want.tok.value, got_value);
                    fails++;
                end
                if (got_start != want.tok.start) begin
                    $error("start_offset: expected %0d, actual %0d", want.tok.start, got_start);
                    fails++;
                end
                if (got_len != want.tok.len) begin
                    $error("token_length: expected %0d, actual %0d", want.tok.len, got_len);
                    fails++;
                end
                if (o_m_axis_tlast != want.last) begin
                    $error("last_of_run: expected %0d, actual %0d", want.last, o_m_axis_tlast);
                    fails++;
                end
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL source_token_lexer_core");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < DIR_N; i++) src_q.push_back(dir_rows[i]);
        while (src_q.size() < DIR_N + RANDOM_ITEMS) gen_source();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (src_q.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (fails == 0) begin
            $display("PASS source_token_lexer_core");
        end else begin
            $display("FAIL source_token_lexer_core");
        end
        $finish;
    end

endmodule
